// ===== rtl/mandelbrot_mask_histogram_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot mask histogram core
// Shared concurrent assertion forms, all reporting through $error.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_MASK_HISTOGRAM_CORE_DEFINES_SVH
`define MANDELBROT_MASK_HISTOGRAM_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mmh_pkg.sv =====
// ----------------------------------------------------------------------------
// mmh_pkg
// Shared types, constants and command codes of the Mandelbrot mask histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package mmh_pkg;

    localparam int MAX_POINTS_DEF  = 8;
    localparam int COORD_BITS_DEF  = 32;
    localparam int CHECK_GROUP_DEF = 4;

    localparam int ITER_BITS  = 16;
    localparam int PIU_BITS   = 4;
    localparam int CMD_BITS   = 2;
    localparam int INDEX_BITS = 8;
    localparam int COUNT_BITS = 32;

    // command / result kind codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD = 2'd0,
        CMD_TEST = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_ITERATIONS = 2'd0;
    localparam logic [1:0] REG_VERIFY     = 2'd1;
    localparam logic [1:0] REG_POINTS     = 2'd2;

    // request from the controller to the escape engine
    typedef struct packed {
        logic                 start;
        logic [ITER_BITS-1:0] iters;
    } eng_req_t;

    // engine status back to the controller
    typedef struct packed {
        logic busy;
        logic done;
    } eng_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mmh_escape_engine.sv =====
// ----------------------------------------------------------------------------
// mmh_escape_engine
// Computes the member mask of all points in use for one offset, one point at
// a time, with one shared multiplier used three times per iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_escape_engine #(
    parameter int MAX_POINTS  = mmh_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS  = mmh_pkg::COORD_BITS_DEF,
    parameter int CHECK_GROUP = mmh_pkg::CHECK_GROUP_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mmh_pkg::eng_req_t                   req,
    input  wire logic [mmh_pkg::PIU_BITS-1:0]        points_in_use,
    input  wire logic signed [COORD_BITS-1:0]        off_re,
    input  wire logic signed [COORD_BITS-1:0]        off_im,
    // point memory write side
    input  wire logic                                pt_we,
    input  wire logic [mmh_pkg::INDEX_BITS-1:0]      pt_waddr,
    input  wire logic signed [COORD_BITS-1:0]        pt_wre,
    input  wire logic signed [COORD_BITS-1:0]        pt_wim,
    output      mmh_pkg::eng_sts_t                   sts,
    output      logic [MAX_POINTS-1:0]               mask
);

    localparam int FRAC  = COORD_BITS - 4;
    localparam int PIDX  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PCNT  = $clog2(MAX_POINTS + 1);
    localparam int VW    = COORD_BITS + 4;        // working value width
    localparam int UW    = COORD_BITS;            // operand magnitude width
    localparam int GW    = mmh_pkg::ITER_BITS + 1;
    localparam int GPW   = (CHECK_GROUP > 1) ? $clog2(CHECK_GROUP) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_RD    = 7'b000_0010,
        S_INIT  = 7'b000_0100,
        S_MXX   = 7'b000_1000,
        S_MYY   = 7'b001_0000,
        S_MXY   = 7'b010_0000,
        S_UPD   = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;

    // point memory, one synchronous read port, reset cleared by valid bits
    logic signed [COORD_BITS-1:0] pre_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] pim_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0]        pvalid_reg;
    logic signed [COORD_BITS-1:0] rd_re_reg, rd_im_reg;
    logic                         rd_v_reg;
    logic [PIDX-1:0]              pidx_reg, pidx_next;
    logic [PCNT-1:0]              npts;
    logic                         wr_ok;

    assign wr_ok = pt_we && ({{(32-mmh_pkg::INDEX_BITS){1'b0}}, pt_waddr} < MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            pre_mem[pt_waddr[PIDX-1:0]] <= pt_wre;
            pim_mem[pt_waddr[PIDX-1:0]] <= pt_wim;
        end
        rd_re_reg <= pre_mem[pidx_reg];
        rd_im_reg <= pim_mem[pidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            rd_v_reg   <= 1'b0;
        end
        else
        begin
            if (wr_ok)
                pvalid_reg[pt_waddr[PIDX-1:0]] <= 1'b1;
            rd_v_reg <= pvalid_reg[pidx_reg];
        end
    end

    // clamp the point count
    always_comb
    begin
        if ({{(32-mmh_pkg::PIU_BITS){1'b0}}, points_in_use} > MAX_POINTS)
            npts = PCNT'(MAX_POINTS);
        else
            npts = PCNT'(points_in_use);
    end

    // iteration datapath registers
    logic signed [VW-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [VW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [VW-1:0] xx_reg, yy_reg, xy_reg, xx_next, yy_next, xy_next;
    logic [GW-1:0]        n_reg, n_next;
    logic [GPW-1:0]       grp_reg, grp_next;
    logic [mmh_pkg::ITER_BITS-1:0] iters_reg, iters_next;
    logic [MAX_POINTS-1:0] mask_reg, mask_next;
    logic                 done_reg, done_next;

    // shared multiplier: magnitude product, truncated toward zero
    // (values stay below 16 in magnitude, so magnitudes fit in UW bits)
    logic signed [VW-1:0] ma, mb, mres;
    logic [UW-1:0]        ua, ub;
    logic [2*UW-1:0]      uprod;
    logic [VW-1:0]        ushift;
    logic                 mneg;

    always_comb
    begin
        case (state_reg)
            S_MXX:   begin ma = x_reg;  mb = x_reg; end
            S_MYY:   begin ma = y_reg;  mb = y_reg; end
            S_MXY:   begin ma = x_reg <<< 1; mb = y_reg; end
            default: begin ma = x_reg;  mb = x_reg; end
        endcase
        mneg   = ma[VW-1] ^ mb[VW-1];
        ua     = ma[VW-1] ? UW'(-ma) : UW'(ma);
        ub     = mb[VW-1] ? UW'(-mb) : UW'(mb);
        uprod  = (2*UW)'(ua) * (2*UW)'(ub);
        ushift = VW'(uprod >> FRAC);
        mres   = mneg ? -$signed(ushift) : $signed(ushift);
    end

    localparam logic signed [VW-1:0] LIM  = VW'(2) <<< FRAC;
    localparam logic signed [VW-1:0] FOUR = VW'(4) <<< FRAC;

    logic signed [COORD_BITS-1:0] pt_re, pt_im;
    logic signed [VW-1:0] sre, sim, nx, ny;
    logic signed [VW:0]   mag;
    logic                 in_range, cnt_done, last_pt, pt_end;

    always_comb
    begin
        pt_re = rd_v_reg ? rd_re_reg : '0;
        pt_im = rd_v_reg ? rd_im_reg : '0;
        sre = VW'(pt_re) + VW'(off_re);
        sim = VW'(pt_im) + VW'(off_im);
        nx  = xx_reg - yy_reg + cx_reg;
        ny  = xy_reg + cy_reg;
        mag = (VW+1)'(xx_reg) + (VW+1)'(mres);
        in_range = !(sre > LIM || sre < -LIM || sim > LIM || sim < -LIM);
        // count rounded up to a whole group
        cnt_done = (n_reg >= GW'(iters_reg)) && (grp_reg == '0);
        last_pt  = ((PCNT'(pidx_reg) + 1'b1) == npts);
    end

    always_comb
    begin
        state_next = state_reg;
        pidx_next  = pidx_reg;
        cx_next = cx_reg; cy_next = cy_reg; x_next = x_reg; y_next = y_reg;
        xx_next = xx_reg; yy_next = yy_reg; xy_next = xy_reg;
        n_next = n_reg; grp_next = grp_reg; iters_next = iters_reg;
        mask_next  = mask_reg;
        done_next  = 1'b0;
        pt_end     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    pidx_next  = '0;
                    mask_next  = '0;
                    iters_next = req.iters;
                    if (npts == '0)
                        done_next = 1'b1;
                    else
                        state_next = S_RD;
                end
            end
            S_RD:
                state_next = S_INIT;
            S_INIT:
            begin
                cx_next = sre; cy_next = sim; x_next = sre; y_next = sim;
                n_next   = '0;
                grp_next = '0;
                if (iters_reg == '0)
                begin
                    // no iteration: every point is a member
                    mask_next[pidx_reg] = 1'b1;
                    pt_end = 1'b1;
                end
                else if (!in_range)
                    pt_end = 1'b1;
                else
                    state_next = S_MXX;
            end
            S_MXX:
            begin
                xx_next = mres;
                state_next = S_MYY;
            end
            S_MYY:
            begin
                yy_next = mres;
                // escape is only checked after an update
                if (n_reg != '0 && mag > (VW+1)'(FOUR))
                    pt_end = 1'b1;
                else if (cnt_done)
                begin
                    mask_next[pidx_reg] = 1'b1;
                    pt_end = 1'b1;
                end
                else
                    state_next = S_MXY;
            end
            S_MXY:
            begin
                xy_next = mres;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                x_next = nx;
                y_next = ny;
                n_next = n_reg + 1'b1;
                grp_next = (grp_reg == GPW'(CHECK_GROUP - 1)) ? '0 : grp_reg + 1'b1;
                state_next = S_MXX;
            end
            default:
                state_next = S_IDLE;
        endcase
        // move on to the next point or finish
        if (pt_end)
        begin
            if (last_pt)
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                pidx_next  = pidx_reg + 1'b1;
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pidx_reg  <= '0;
            mask_reg  <= '0;
            done_reg  <= 1'b0;
            n_reg     <= '0;
            grp_reg   <= '0;
            iters_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pidx_reg  <= pidx_next;
            mask_reg  <= mask_next;
            done_reg  <= done_next;
            n_reg     <= n_next;
            grp_reg   <= grp_next;
            iters_reg <= iters_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next; cy_reg <= cy_next;
        x_reg  <= x_next;  y_reg  <= y_next;
        xx_reg <= xx_next; yy_reg <= yy_next; xy_reg <= xy_next;
    end

    assign sts  = '{busy: (state_reg != S_IDLE), done: done_reg};
    assign mask = mask_reg;

endmodule

`default_nettype wire

// ===== rtl/mmh_bucket_store.sv =====
// ----------------------------------------------------------------------------
// mmh_bucket_store
// Bucket count and first-offset memories with a registered read.
// Counts are cleared by a sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_bucket_store #(
    parameter int MAX_POINTS = mmh_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mmh_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [MAX_POINTS-1:0]             raddr,
    input  wire logic                              we,
    input  wire logic                              we_off,
    input  wire logic [MAX_POINTS-1:0]             waddr,
    input  wire logic [mmh_pkg::COUNT_BITS-1:0]    wcount,
    input  wire logic [COORD_BITS-1:0]             wre,
    input  wire logic [COORD_BITS-1:0]             wim,
    output      logic [mmh_pkg::COUNT_BITS-1:0]    rcount,
    output      logic [COORD_BITS-1:0]             rre,
    output      logic [COORD_BITS-1:0]             rim,
    output      logic                              ready
);

    localparam int DEPTH = 1 << MAX_POINTS;

    logic [mmh_pkg::COUNT_BITS-1:0] cnt_mem [DEPTH];
    logic [COORD_BITS-1:0]          re_mem  [DEPTH];
    logic [COORD_BITS-1:0]          im_mem  [DEPTH];
    logic [MAX_POINTS:0]            clr_reg;

    // clearing pass over the count memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (!clr_reg[MAX_POINTS])
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!clr_reg[MAX_POINTS])
            cnt_mem[clr_reg[MAX_POINTS-1:0]] <= '0;
        else if (we)
            cnt_mem[waddr] <= wcount;
        if (we_off)
        begin
            re_mem[waddr] <= wre;
            im_mem[waddr] <= wim;
        end
        rcount <= cnt_mem[raddr];
        rre    <= re_mem[raddr];
        rim    <= im_mem[raddr];
    end

    assign ready = clr_reg[MAX_POINTS];

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_mask_histogram_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_mask_histogram_core
// Mandelbrot membership mask histogram over a set of loaded points.
// ----------------------------------------------------------------------------
// One item at a time. A test runs the escape iteration for each point in
// use, one point after another, on one shared multiplier, with the
// iteration count rounded up to a multiple of CHECK_GROUP; an escaping
// point stops early. The same again with verify_iterations when the
// bucket is still empty. After reset the bucket count memory is cleared
// before the first item is taken.
`default_nettype none

`include "mandelbrot_mask_histogram_core_defines.svh"

module mandelbrot_mask_histogram_core #(
    parameter int MAX_POINTS  = mmh_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS  = mmh_pkg::COORD_BITS_DEF,
    parameter int CHECK_GROUP = mmh_pkg::CHECK_GROUP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // cmd[1:0], index[9:2], coord_re, coord_im, zero fill
    input  wire logic [((2+8+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // kind, mask, accepted, first_hit, bucket_total, stored_re, stored_im
    output      logic [((12+32+2*COORD_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int IW = ((2+8+2*COORD_BITS+7)/8)*8;
    localparam int OW = ((12+32+2*COORD_BITS+7)/8)*8;
    localparam int CW = mmh_pkg::COUNT_BITS;

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_MAIN = 7'b0000010,
        C_RD1  = 7'b0000100,
        C_RD2  = 7'b0001000,
        C_VER  = 7'b0010000,
        C_WR   = 7'b0100000,
        C_OUT  = 7'b1000000
    } ctl_t;

    ctl_t st_reg;

    logic [15:0] iter_reg, viter_reg;
    logic [3:0]  piu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg  <= 16'd256;
            viter_reg <= 16'd1024;
            piu_reg   <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mmh_pkg::REG_ITERATIONS: iter_reg  <= cfg_data;
                mmh_pkg::REG_VERIFY:     viter_reg <= cfg_data;
                mmh_pkg::REG_POINTS:     piu_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [1:0]             cmd_reg;
    logic [7:0]             idx_reg;
    logic [COORD_BITS-1:0]  re_reg, im_reg;
    logic [MAX_POINTS-1:0]  m_reg;
    logic                   acc_reg, fh_reg;
    logic [CW-1:0]          tot_reg;
    logic [COORD_BITS-1:0]  sre_reg, sim_reg;
    logic                   ovalid_reg;

    mmh_pkg::eng_req_t req;
    mmh_pkg::eng_sts_t sts;
    logic [MAX_POINTS-1:0] emask;
    logic                  accept;
    logic                  bready;

    // bucket memory
    logic [MAX_POINTS-1:0] baddr;
    logic [CW-1:0]         tot_q;
    logic [COORD_BITS-1:0] bre_q, bim_q;
    logic                  bwe, bwe_off;
    logic [CW-1:0]         newtot;
    logic                  rd_hit;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (st_reg == C_IDLE) && !ovalid_reg && bready;

    // main run on a test transfer, verification on an empty bucket
    assign req = '{start: (accept && s_tdata[1:0] == mmh_pkg::CMD_TEST) ||
                          (st_reg == C_RD2 && cmd_reg == mmh_pkg::CMD_TEST &&
                           tot_q == '0),
                   iters: (st_reg == C_IDLE) ? iter_reg : viter_reg};

    mmh_escape_engine #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .CHECK_GROUP(CHECK_GROUP)
    ) u_eng (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .points_in_use(piu_reg),
        .off_re       ((st_reg == C_IDLE) ? s_tdata[10 +: COORD_BITS] : re_reg),
        .off_im       ((st_reg == C_IDLE) ? s_tdata[10+COORD_BITS +: COORD_BITS] : im_reg),
        .pt_we        (accept && s_tdata[1:0] == mmh_pkg::CMD_LOAD),
        .pt_waddr     (s_tdata[9:2]),
        .pt_wre       (s_tdata[10 +: COORD_BITS]),
        .pt_wim       (s_tdata[10+COORD_BITS +: COORD_BITS]),
        .sts          (sts),
        .mask         (emask)
    );

    assign baddr  = (cmd_reg == mmh_pkg::CMD_READ) ? idx_reg[MAX_POINTS-1:0] : m_reg;
    assign newtot = (tot_q == '1) ? tot_q : tot_q + 1'b1;
    assign bwe    = (st_reg == C_WR);
    assign bwe_off = bwe && (tot_q == '0);

    mmh_bucket_store #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_bkt (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (baddr),
        .we    (bwe),
        .we_off(bwe_off),
        .waddr (m_reg),
        .wcount(newtot),
        .wre   (re_reg),
        .wim   (im_reg),
        .rcount(tot_q),
        .rre   (bre_q),
        .rim   (bim_q),
        .ready (bready)
    );

    assign rd_hit = ({24'd0, idx_reg} < (32'd1 << MAX_POINTS)) && (tot_q != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= C_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                ovalid_reg <= 1'b0;
            case (st_reg)
                C_IDLE:
                    if (accept)
                    begin
                        case (s_tdata[1:0])
                            mmh_pkg::CMD_TEST: st_reg <= C_MAIN;
                            mmh_pkg::CMD_READ: st_reg <= C_RD1;
                            default:           st_reg <= C_OUT;
                        endcase
                    end
                C_MAIN:
                    if (sts.done)
                        st_reg <= C_RD1;
                C_RD1:
                    st_reg <= C_RD2;
                C_RD2:
                    if (cmd_reg == mmh_pkg::CMD_READ)
                        st_reg <= C_OUT;
                    else if (tot_q == '0)
                        st_reg <= C_VER;
                    else
                        st_reg <= C_WR;
                C_VER:
                    if (sts.done)
                        st_reg <= (emask == m_reg) ? C_WR : C_OUT;
                C_WR:
                    st_reg <= C_OUT;
                C_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    st_reg     <= C_IDLE;
                end
                default:
                    st_reg <= C_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tdata[1:0];
            idx_reg <= s_tdata[9:2];
            re_reg  <= s_tdata[10 +: COORD_BITS];
            im_reg  <= s_tdata[10+COORD_BITS +: COORD_BITS];
            acc_reg <= 1'b0;
            fh_reg  <= 1'b0;
            tot_reg <= '0;
            sre_reg <= '0;
            sim_reg <= '0;
            m_reg   <= '0;
        end
        if (st_reg == C_MAIN && sts.done)
            m_reg <= emask;
        if (st_reg == C_RD2 && cmd_reg == mmh_pkg::CMD_READ && rd_hit)
        begin
            tot_reg <= tot_q;
            sre_reg <= bre_q;
            sim_reg <= bim_q;
        end
        if (st_reg == C_WR)
        begin
            acc_reg <= 1'b1;
            fh_reg  <= (tot_q == '0);
            tot_reg <= newtot;
            sre_reg <= (tot_q == '0) ? re_reg : bre_q;
            sim_reg <= (tot_q == '0) ? im_reg : bim_q;
        end
    end

    logic [7:0] mask_out;
    always_comb
    begin
        mask_out = '0;
        if (cmd_reg == mmh_pkg::CMD_READ)
            mask_out = idx_reg;
        else if (cmd_reg == mmh_pkg::CMD_TEST)
            mask_out = 8'(m_reg);
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = OW'({sim_reg, sre_reg, tot_reg, fh_reg, acc_reg, mask_out, cmd_reg});

    logic unused_ok;
    assign unused_ok = ^s_tdata[IW-1:10+2*COORD_BITS] | sts.busy;

    `MMH_ASSERT_IMPL(a_ready_idle, clk, rst_n, s_tready, st_reg == C_IDLE,
        "input taken while busy")
    `MMH_ASSERT_NEXT(a_out_after, clk, rst_n, st_reg == C_OUT, m_tvalid,
        "result not presented")
    `MMH_ASSERT_IMPL(a_wr_test, clk, rst_n, st_reg == C_WR, cmd_reg == mmh_pkg::CMD_TEST,
        "bucket write outside a test")

endmodule

`default_nettype wire
